FILE: hdl/lcdns_pkg.sv
// Shared types, constants and lookup functions of the LCD nibble command sequencer.
package lcdns_pkg;

    localparam int WAIT_W      = 14;
    localparam int STEP_W      = 4;
    localparam int INIT_STEPS  = 12;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [STEP_W-1:0] INIT_LAST_STEP = STEP_W'(INIT_STEPS - 1);
    localparam logic [STEP_W-1:0] PAIR_LAST_STEP = STEP_W'(1);

    // DDRAM line start addresses and command codes
    localparam logic [7:0] LINE1_ADDR    = 8'h00;
    localparam logic [7:0] LINE2_ADDR    = 8'h40;
    localparam logic [7:0] LINE3_ADDR    = 8'h14;
    localparam logic [7:0] LINE4_ADDR    = 8'h54;
    localparam logic [7:0] SET_DDRAM_CMD = 8'h80;
    localparam logic [7:0] CLEAR_CMD     = 8'h01;

    // Waits in half-microsecond units
    localparam logic [WAIT_W-1:0] CHAR_WAIT_HI  = 14'd2;
    localparam logic [WAIT_W-1:0] CHAR_WAIT_LO  = 14'd76;
    localparam logic [WAIT_W-1:0] LINE_WAIT_HI  = 14'd1;
    localparam logic [WAIT_W-1:0] LINE_WAIT_LO  = 14'd80;
    localparam logic [WAIT_W-1:0] CLEAR_WAIT_HI = 14'd2;
    localparam logic [WAIT_W-1:0] CLEAR_WAIT_LO = 14'd3200;

    typedef enum logic [1:0] {
        REQ_INIT  = 2'd0,
        REQ_CHAR  = 2'd1,
        REQ_LINE  = 2'd2,
        REQ_CLEAR = 2'd3
    } t_req_kind;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } t_back_state;

    // Classified request handed from front to back
    typedef struct packed {
        t_req_kind  kind;
        logic [7:0] cmd_byte;
    } t_cmd;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [3:0] init_nibble(input logic [STEP_W-1:0] step);
        logic [3:0] nib;
        case (step)
            4'd0:    nib = 4'h3;
            4'd1:    nib = 4'h3;
            4'd2:    nib = 4'h3;
            4'd3:    nib = 4'h2;
            4'd4:    nib = 4'h2;
            4'd5:    nib = 4'hA;
            4'd6:    nib = 4'h0;
            4'd7:    nib = 4'hB;
            4'd8:    nib = 4'h0;
            4'd9:    nib = 4'hF;
            4'd10:   nib = 4'h0;
            4'd11:   nib = 4'h6;
            default: nib = 4'h0;
        endcase
        return nib;
    endfunction

    function automatic logic [WAIT_W-1:0] init_wait(input logic [STEP_W-1:0] step);
        logic [WAIT_W-1:0] w;
        case (step)
            4'd0:    w = 14'd8200;
            4'd1:    w = 14'd76;
            4'd2:    w = 14'd76;
            4'd3:    w = 14'd76;
            4'd4:    w = 14'd200;
            4'd5:    w = 14'd76;
            4'd6:    w = 14'd2;
            4'd7:    w = 14'd76;
            4'd8:    w = 14'd2;
            4'd9:    w = 14'd76;
            4'd10:   w = 14'd2;
            4'd11:   w = 14'd78;
            default: w = 14'd0;
        endcase
        return w;
    endfunction

endpackage

FILE: hdl/lcdns_front.sv
// Front end: takes requests, classifies them into command bytes, drops empty ones.
module lcdns_front (
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_req_type,
    input  logic [7:0]           i_char_code,
    input  logic [2:0]           i_line_number,
    input  lcdns_pkg::t_q_status i_q_status,
    output logic                 o_push,
    output lcdns_pkg::t_cmd      o_cmd
);

    logic       line_ok;
    logic [7:0] line_addr;

    always_comb begin
        line_ok   = 1'b1;
        line_addr = lcdns_pkg::LINE1_ADDR;
        case (i_line_number)
            3'd1:    line_addr = lcdns_pkg::LINE1_ADDR;
            3'd2:    line_addr = lcdns_pkg::LINE2_ADDR;
            3'd3:    line_addr = lcdns_pkg::LINE3_ADDR;
            3'd4:    line_addr = lcdns_pkg::LINE4_ADDR;
            default: line_ok   = 1'b0;
        endcase
    end

    always_comb begin
        o_cmd.kind     = lcdns_pkg::t_req_kind'(i_req_type);
        o_cmd.cmd_byte = i_char_code;
        case (o_cmd.kind)
            lcdns_pkg::REQ_LINE:  o_cmd.cmd_byte = lcdns_pkg::SET_DDRAM_CMD | line_addr;
            lcdns_pkg::REQ_CLEAR: o_cmd.cmd_byte = lcdns_pkg::CLEAR_CMD;
            default:              o_cmd.cmd_byte = i_char_code;
        endcase
    end

    // Drop a line request outside 1..4: accept it, queue nothing
    assign o_in_ready = !i_q_status.full;
    assign o_push     = i_in_valid && o_in_ready &&
                        !((o_cmd.kind == lcdns_pkg::REQ_LINE) && !line_ok);

endmodule

FILE: hdl/lcdns_queue.sv
// Short command queue between the front end and the transfer sequencer.
module lcdns_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  lcdns_pkg::t_cmd      i_cmd,
    input  logic                 i_pop,
    output lcdns_pkg::t_cmd      o_cmd,
    output lcdns_pkg::t_q_status o_status
);

    lcdns_pkg::t_cmd                r_slot [lcdns_pkg::QUEUE_DEPTH];
    logic [lcdns_pkg::QPTR_W-1:0]   r_wptr, n_wptr;
    logic [lcdns_pkg::QPTR_W-1:0]   r_rptr, n_rptr;
    logic [lcdns_pkg::QCNT_W-1:0]   r_count, n_count;

    localparam logic [lcdns_pkg::QPTR_W-1:0] PTR_LAST =
        lcdns_pkg::QPTR_W'(lcdns_pkg::QUEUE_DEPTH - 1);
    localparam logic [lcdns_pkg::QCNT_W-1:0] CNT_FULL =
        lcdns_pkg::QCNT_W'(lcdns_pkg::QUEUE_DEPTH);

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    assign o_cmd          = r_slot[r_rptr];
    assign o_status.full  = (r_count == CNT_FULL);
    assign o_status.empty = (r_count == '0);

endmodule

FILE: hdl/lcdns_back.sv
// Back end: walks each queued command through its nibble transfers into the output register.
module lcdns_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lcdns_pkg::t_cmd            i_cmd,
    input  lcdns_pkg::t_q_status       i_q_status,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_reg_select,
    output logic [3:0]                 o_nibble,
    output logic                       o_setup_half_us,
    output logic [lcdns_pkg::WAIT_W-1:0] o_wait_half_us,
    output logic                       o_last_transfer
);

    lcdns_pkg::t_back_state          r_state, n_state;
    lcdns_pkg::t_cmd                 r_cmd;
    logic [lcdns_pkg::STEP_W-1:0]    r_step;

    logic                            r_out_valid;
    logic                            r_rs;
    logic [3:0]                      r_nib;
    logic                            r_setup;
    logic [lcdns_pkg::WAIT_W-1:0]    r_wait;
    logic                            r_last;

    logic                            adv;
    logic                            x_rs;
    logic [3:0]                      x_nib;
    logic                            x_setup;
    logic [lcdns_pkg::WAIT_W-1:0]    x_wait;
    logic                            x_last;

    // Current transfer from the held command and step
    always_comb begin
        x_rs    = 1'b0;
        x_setup = 1'b0;
        x_nib   = r_step[0] ? r_cmd.cmd_byte[3:0] : r_cmd.cmd_byte[7:4];
        x_last  = (r_step == lcdns_pkg::PAIR_LAST_STEP);
        x_wait  = '0;
        case (r_cmd.kind)
            lcdns_pkg::REQ_INIT: begin
                x_nib  = lcdns_pkg::init_nibble(r_step);
                x_wait = lcdns_pkg::init_wait(r_step);
                x_last = (r_step == lcdns_pkg::INIT_LAST_STEP);
            end
            lcdns_pkg::REQ_CHAR: begin
                x_rs    = 1'b1;
                x_setup = 1'b1;
                x_wait  = r_step[0] ? lcdns_pkg::CHAR_WAIT_LO : lcdns_pkg::CHAR_WAIT_HI;
            end
            lcdns_pkg::REQ_LINE: begin
                x_wait = r_step[0] ? lcdns_pkg::LINE_WAIT_LO : lcdns_pkg::LINE_WAIT_HI;
            end
            default: begin
                x_wait = r_step[0] ? lcdns_pkg::CLEAR_WAIT_LO : lcdns_pkg::CLEAR_WAIT_HI;
            end
        endcase
    end

    // Outputs of the sequencer state machine
    always_comb begin
        adv   = (r_state == lcdns_pkg::BK_RUN) && (!r_out_valid || i_out_ready);
        o_pop = 1'b0;
        case (r_state)
            lcdns_pkg::BK_IDLE: o_pop = !i_q_status.empty;
            lcdns_pkg::BK_RUN:  o_pop = adv && x_last && !i_q_status.empty;
            default:            o_pop = 1'b0;
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lcdns_pkg::BK_IDLE: begin
                if (!i_q_status.empty) begin
                    n_state = lcdns_pkg::BK_RUN;
                end
            end
            lcdns_pkg::BK_RUN: begin
                if (adv && x_last && i_q_status.empty) begin
                    n_state = lcdns_pkg::BK_IDLE;
                end
            end
            default: n_state = lcdns_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lcdns_pkg::BK_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_step <= '0;
            end else if (adv) begin
                r_step <= r_step + 1'b1;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (adv) begin
            r_rs    <= x_rs;
            r_nib   <= x_nib;
            r_setup <= x_setup;
            r_wait  <= x_wait;
            r_last  <= x_last;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_reg_select    = r_rs;
    assign o_nibble        = r_nib;
    assign o_setup_half_us = r_setup;
    assign o_wait_half_us  = r_wait;
    assign o_last_transfer = r_last;

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_pop && i_q_status.empty))
        else $error("command popped from empty queue");

    a_pair_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lcdns_pkg::BK_RUN && r_cmd.kind != lcdns_pkg::REQ_INIT)
        |-> (r_step <= lcdns_pkg::PAIR_LAST_STEP))
        else $error("two-transfer command ran past its last step");

    a_init_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lcdns_pkg::BK_RUN && r_cmd.kind == lcdns_pkg::REQ_INIT)
        |-> (r_step <= lcdns_pkg::INIT_LAST_STEP))
        else $error("init sequence ran past its last step");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == lcdns_pkg::BK_IDLE && !$past(r_state == lcdns_pkg::BK_IDLE) && r_out_valid)
        |-> r_last)
        else $error("sequencer went idle before the final transfer");

endmodule

FILE: hdl/char_lcd_nibble_command_sequencer.sv
// Top level of the character LCD nibble command sequencer (4-bit interface).
//
// Turns each request (initialize, write character, set line address, clear
// display) into a run of nibble transfers, each carrying the RS level, the
// nibble for D7..D4, the data setup before enable and the wait after the
// enable pulse, both in half-microsecond units; the final transfer of a
// request is flagged with o_last_transfer. Initialize gives 12 transfers, the
// other requests give 2, and a line request with a line number outside 1 to 4
// is accepted and gives none. A front end classifies each request into a
// command byte and pushes it into a two-entry queue; a back-end sequencer
// pops commands and emits one transfer per cycle into a registered output
// while the output side keeps taking them, and the sequencer moves straight
// from the last transfer of one request to the first of the next. Requests
// are taken while the queue has room, so up to two requests can be waiting
// behind the one in flight; a request taken into an empty block passes
// through the queue slot and the held command register before its first
// transfer reaches the output register. Stalls on the output hold the current
// transfer and stall only the back end; the front keeps filling the queue.
module char_lcd_nibble_command_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_char_code,
    input  logic [2:0]  i_line_number,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_reg_select,
    output logic [3:0]  o_nibble,
    output logic        o_setup_half_us,
    output logic [13:0] o_wait_half_us,
    output logic        o_last_transfer
);

    lcdns_pkg::t_cmd      front_cmd;
    lcdns_pkg::t_cmd      head_cmd;
    lcdns_pkg::t_q_status q_status;
    logic                 push;
    logic                 pop;

    // Classify the request and decide whether it queues anything
    lcdns_front u_front (
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_req_type    (i_req_type),
        .i_char_code   (i_char_code),
        .i_line_number (i_line_number),
        .i_q_status    (q_status),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    // Hold classified commands so front and back stall independently
    lcdns_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (head_cmd),
        .o_status (q_status)
    );

    // Advance through the transfers of the head command
    lcdns_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (head_cmd),
        .i_q_status      (q_status),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_reg_select    (o_reg_select),
        .o_nibble        (o_nibble),
        .o_setup_half_us (o_setup_half_us),
        .o_wait_half_us  (o_wait_half_us),
        .o_last_transfer (o_last_transfer)
    );

endmodule
